// ----- sv/block_median_filter_top_assert.svh -----
// Assertion macros for the block median filter.
// Included by bmf_ctrl, which checks its own control logic; no dependencies.
`ifndef BLOCK_MEDIAN_FILTER_TOP_ASSERT_SVH
`define BLOCK_MEDIAN_FILTER_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define BMF_ASSERT_IMP(lbl, clk, rstn, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |-> (con)) \
        else $error("bmf: same-cycle check failed");
// next-cycle implication
`define BMF_ASSERT_NXT(lbl, clk, rstn, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |=> (con)) \
        else $error("bmf: next-cycle check failed");
`else
`define BMF_ASSERT_IMP(lbl, clk, rstn, ant, con)
`define BMF_ASSERT_NXT(lbl, clk, rstn, ant, con)
`endif

`endif

// ----- sv/bmf_pkg.sv -----
// Shared types and constants for the block median filter.
// No dependencies.
package bmf_pkg;

    localparam int SAMPLE_W        = 12;
    localparam int COUNT_W         = 8;
    localparam int MAX_SAMPLES_DEF = 128;

    // controller phases
    typedef enum logic [0:0] {
        ST_FILL  = 1'b0,
        ST_DRAIN = 1'b1
    } bmf_state_t;

    // command broadcast to every cell of the sorting chain
    typedef struct packed {
        logic                ins;
        logic                shift;
        logic [SAMPLE_W-1:0] sample;
    } bmf_cell_ctl_t;

endpackage

// ----- sv/bmf_cell.sv -----
// One cell of the insertion-sort chain: holds one sample of the sorted block.
// Depends on bmf_pkg.
module bmf_cell
    import bmf_pkg::*;
(
    input  logic                aclk,
    input  bmf_cell_ctl_t       ctl_i,
    input  logic                occ_i,      // cell holds a sample of this block
    input  logic                prev_gt_i,  // lower neighbour is above the new sample
    input  logic [SAMPLE_W-1:0] prev_val_i,
    input  logic [SAMPLE_W-1:0] next_val_i,
    output logic [SAMPLE_W-1:0] val_o,
    output logic                gt_o
);

    logic [SAMPLE_W-1:0] val_reg;
    logic [SAMPLE_W-1:0] val_next;

    // empty cells count as larger than any sample
    assign gt_o  = !occ_i || (val_reg > ctl_i.sample);
    assign val_o = val_reg;

    // insert: move up or take the new sample; drain: move towards cell 0
    always_comb begin
        val_next = val_reg;
        if (ctl_i.ins && gt_o) begin
            val_next = prev_gt_i ? prev_val_i : ctl_i.sample;
        end else if (ctl_i.shift) begin
            val_next = next_val_i;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

// ----- sv/bmf_ctrl.sv -----
// Controller of the block median filter: fill count, drop flag, drain
// counter and result register. Depends on bmf_pkg and the assertion header.
`include "block_median_filter_top_assert.svh"

module bmf_ctrl
    import bmf_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    localparam int FILL_W     = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_sample,
    input  logic                s_last,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_median,
    output logic [COUNT_W-1:0]  m_count,
    output logic                m_overflow,
    input  logic [SAMPLE_W-1:0] head_val,   // cell 0 of the chain
    output bmf_cell_ctl_t       ctl,
    output logic [FILL_W-1:0]   fill
);

    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_SAMPLES);

    bmf_state_t          state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                drop_reg, drop_next;
    logic [FILL_W-1:0]   shcnt_reg, shcnt_next;
    logic                mvalid_reg, mvalid_next;
    logic [SAMPLE_W-1:0] med_reg, med_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;

    logic                s_accept;
    logic                room;
    logic                load;
    logic [FILL_W-1:0]   fill_inc;

    assign s_tready   = (state_reg == ST_FILL);
    assign s_accept   = s_tvalid && s_tready;
    assign room       = (fill_reg < FILL_MAX);
    assign fill_inc   = fill_reg + FILL_W'(1);
    assign fill       = fill_reg;
    assign m_tvalid   = mvalid_reg;
    assign m_median   = med_reg;
    assign m_count    = cnt_reg;
    assign m_overflow = ovf_reg;

    // next state, chain commands and result capture
    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        drop_next   = drop_reg;
        shcnt_next  = shcnt_reg;
        mvalid_next = mvalid_reg;
        med_next    = med_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        load        = 1'b0;
        ctl.ins     = 1'b0;
        ctl.shift   = 1'b0;
        ctl.sample  = s_sample;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_FILL: begin
                if (s_accept) begin
                    if (room) begin
                        ctl.ins   = 1'b1;
                        fill_next = fill_inc;
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (s_last) begin
                        // walk the chain down to the element at count/2
                        shcnt_next = (room ? fill_inc : fill_reg) >> 1;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (shcnt_reg != '0) begin
                    ctl.shift  = 1'b1;
                    shcnt_next = shcnt_reg - FILL_W'(1);
                end else if (!mvalid_reg || m_tready) begin
                    load        = 1'b1;
                    med_next    = head_val;
                    cnt_next    = COUNT_W'(fill_reg);
                    ovf_next    = drop_reg;
                    mvalid_next = 1'b1;
                    fill_next   = '0;
                    drop_next   = 1'b0;
                    state_next  = ST_FILL;
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_FILL;
            fill_reg   <= '0;
            drop_reg   <= 1'b0;
            shcnt_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            drop_reg   <= drop_next;
            shcnt_reg  <= shcnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        med_reg <= med_next;
        cnt_reg <= cnt_next;
        ovf_reg <= ovf_next;
    end

    `BMF_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= FILL_MAX)
    `BMF_ASSERT_IMP(a_drop_only_full, aclk, aresetn, drop_reg, fill_reg == FILL_MAX)
    `BMF_ASSERT_NXT(a_load_clears, aclk, aresetn, load, (fill_reg == '0) && !drop_reg && mvalid_reg)
    `BMF_ASSERT_IMP(a_drain_half, aclk, aresetn, state_reg == ST_DRAIN, (shcnt_reg << 1) <= fill_reg)

endmodule

// ----- sv/block_median_filter_top.sv -----
// Block median filter top level: chain of sorting cells plus controller.
// Depends on bmf_pkg, bmf_cell and bmf_ctrl.
//
// Usage:
//   Samples enter on the s_ channel, one per request; s_tlast marks the last
//   sample of a block. Each sample is placed in a sorted chain of MAX_SAMPLES
//   cells in the cycle it is taken, so samples of a block stream at one per
//   cycle. Samples beyond MAX_SAMPLES are dropped and flagged.
//   After the last sample the chain shifts towards cell 0 count/2 times (one
//   shift per cycle), then the median is captured and the result request
//   appears on the m_ channel. s_tready is low during that drain; count is
//   n capped at MAX_SAMPLES for a block of n samples. The result register
//   parts the two sides: a new block is taken while a result waits; if the
//   next block finishes before the receiver takes the old result, the drain
//   holds at its end until it does. Reset (aresetn low, synchronous) empties
//   the block and drops any result not yet taken; the cell contents need no
//   clearing.
module block_median_filter_top
    import bmf_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    localparam int FILL_W     = $clog2(MAX_SAMPLES + 1)
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
    input  logic        s_tlast,   // last sample of the block
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [11:0] median, [19:12] count_used, [23:20] zero
    output logic        m_tuser    // [0] overflow
);

    bmf_cell_ctl_t       ctl;
    logic [FILL_W-1:0]   fill;
    logic [SAMPLE_W-1:0] median;
    logic [COUNT_W-1:0]  count_used;
    logic                overflow;

    logic [SAMPLE_W-1:0] val  [MAX_SAMPLES];
    logic                gt   [MAX_SAMPLES];
    logic                occ  [MAX_SAMPLES];

    bmf_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_sample   (s_tdata[SAMPLE_W-1:0]),
        .s_last     (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_median   (median),
        .m_count    (count_used),
        .m_overflow (overflow),
        .head_val   (val[0]),
        .ctl        (ctl),
        .fill       (fill)
    );

    // sorting chain: cell i is occupied when i is below the fill count
    for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
        assign occ[i] = (FILL_W'(i) < fill);

        bmf_cell u_cell (
            .aclk       (aclk),
            .ctl_i      (ctl),
            .occ_i      (occ[i]),
            .prev_gt_i  ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
            .prev_val_i (val[(i == 0) ? 0 : i - 1]),
            .next_val_i (val[(i == MAX_SAMPLES - 1) ? i : i + 1]),
            .val_o      (val[i]),
            .gt_o       (gt[i])
        );
    end

    assign m_tdata = {4'b0000, count_used, median};
    assign m_tuser = overflow;

endmodule

// ----- test/block_median_filter_top_test.sv -----
// Self-checking testbench for block_median_filter_top: streams sample blocks,
// predicts each block's median, count and overflow flag and checks every result.
// Depends on bmf_pkg and block_median_filter_top.
module block_median_filter_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bmf_pkg::*;

    localparam int SETTLE_CYCLES = MAX_SAMPLES_DEF / 2 + 16;

    // expected outcome of one block
    typedef struct {
        logic [SAMPLE_W-1:0] median;
        logic [COUNT_W-1:0]  count_used;
        logic                overflow;
    } median_result_t;

    // how the values of one block are drawn
    typedef enum int {
        MIX_SPREAD,
        MIX_CLUSTER,
        MIX_EXTREME
    } value_mix_t;

    // sorted store of the current block plus the results still owed by the DUT
    class median_scoreboard;
        logic [SAMPLE_W-1:0] cells [MAX_SAMPLES_DEF];
        int unsigned         fill;
        bit                  dropped;
        median_result_t      pending_medians [$];
        int                  errors;

        // accepted sample request: insertion into the sorted store, or a drop when full; the last one queues the result
        function void note_sample(logic [SAMPLE_W-1:0] sample, logic last);
            int unsigned    pos;
            median_result_t res;
            if (fill < MAX_SAMPLES_DEF) begin
                pos = fill;
                while (pos > 0 && cells[pos-1] > sample) begin
                    cells[pos] = cells[pos-1];
                    pos--;
                end
                cells[pos] = sample;
                fill++;
            end else begin
                dropped = 1'b1;
            end
            if (last) begin
                res.median     = cells[fill/2];
                res.count_used = COUNT_W'(fill);
                res.overflow   = dropped;
                pending_medians.push_back(res);
                fill    = 0;
                dropped = 1'b0;
            end
        endfunction

        // accepted result request: compare with the oldest expectation
        function void check_result(logic [SAMPLE_W-1:0] median, logic [COUNT_W-1:0] count_used,
                                   logic overflow);
            median_result_t exp_res;
            if (pending_medians.size() == 0) begin
                $error("unexpected result: median %0d count_used %0d overflow %0d",
                       median, count_used, overflow);
                errors++;
                return;
            end
            exp_res = pending_medians.pop_front();
            if (median !== exp_res.median) begin
                $error("median: expected %0d, actual %0d", exp_res.median, median);
                errors++;
            end
            if (count_used !== exp_res.count_used) begin
                $error("count_used: expected %0d, actual %0d", exp_res.count_used, count_used);
                errors++;
            end
            if (overflow !== exp_res.overflow) begin
                $error("overflow: expected %0d, actual %0d", exp_res.overflow, overflow);
                errors++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [11:0] sample, [15:12] zero
    logic        s_tlast  = 1'b0; // last sample of the block
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [11:0] median, [19:12] count_used, [23:20] zero
    logic        m_tuser;         // [0] overflow

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    median_scoreboard sb = new();

    block_median_filter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watch both channels; values seen here are the ones before the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_sample(s_tdata[SAMPLE_W-1:0], s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[SAMPLE_W-1:0], m_tdata[SAMPLE_W +: COUNT_W], m_tuser);
        end
    end

    // one sample request, with random gaps before it
    task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, sample};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(value_mix_t mix,
                                                        logic [SAMPLE_W-1:0] base);
        case (mix)
            MIX_CLUSTER: return base + SAMPLE_W'($urandom_range(7));
            MIX_EXTREME: begin
                case ($urandom_range(2))
                    0:       return '0;
                    1:       return '1;
                    default: return SAMPLE_W'($urandom_range(4095));
                endcase
            end
            default:     return SAMPLE_W'($urandom_range(4095));
        endcase
    endfunction

    task automatic send_block(input int len);
        value_mix_t          mix;
        logic [SAMPLE_W-1:0] base;
        mix  = value_mix_t'($urandom_range(2));
        base = SAMPLE_W'($urandom_range(4095));
        for (int i = 0; i < len; i++)
            send_sample(pick_sample(mix, base), i == len - 1);
    endtask

    // one idling setting; every phase opens with an overflowing block and a full one
    task automatic run_phase(input int items, input int sidle, input int ridle);
        int sent;
        int len;
        int pick;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(19);
            if (sent == 0)
                len = $urandom_range(MAX_SAMPLES_DEF + 1, MAX_SAMPLES_DEF + 22);
            else if (sent < MAX_SAMPLES_DEF + 23 || pick == 0)
                len = MAX_SAMPLES_DEF;
            else if (pick <= 2)
                len = $urandom_range(MAX_SAMPLES_DEF - 8, MAX_SAMPLES_DEF + 22);
            else
                len = $urandom_range(1, 24);
            send_block(len);
            sent += len;
        end
    endtask

    // directed blocks: {last, sample} pairs, bit 12 is the last flag
    logic [12:0] directed_items [18] = '{
        {1'b1, 12'h000},
        {1'b1, 12'hFFF},
        {1'b0, 12'h000}, {1'b1, 12'hFFF},
        {1'b0, 12'hFFF}, {1'b1, 12'h000},
        {1'b0, 12'h007}, {1'b0, 12'h007}, {1'b1, 12'h007},
        {1'b0, 12'hAAA}, {1'b0, 12'h555}, {1'b0, 12'hFFF}, {1'b1, 12'h000},
        {1'b0, 12'h005}, {1'b0, 12'h003}, {1'b0, 12'h009}, {1'b0, 12'h001},
        {1'b1, 12'h007}
    };

    // main sequence
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_items[i])
            send_sample(directed_items[i][11:0], directed_items[i][12]);

        run_phase(433, 33, 62);
        run_phase(433, 62, 33);
        run_phase(434, 0, 0);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // let the last drain finish, then a margin for stray results
        while (sb.pending_medians.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.pending_medians.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
